[rtl/mjt_pkg.sv]
// ----------------------------------------------------------------------------
// Minimum-jerk trajectory package
// Shared types, codes and sizes of the quintic move evaluator.
// ----------------------------------------------------------------------------
package mjt_pkg;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_MOVING = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_START_TIME = 2'd0,
    REG_START_POS  = 2'd1,
    REG_END_POS    = 2'd2,
    REG_DURATION   = 2'd3
  } reg_idx_t;

  localparam int TIME_W   = 40;
  localparam int POS_W    = 32;
  localparam int DUR_W    = 32;
  localparam int RATE_W   = 48;
  localparam int CFG_W    = 40;
  localparam int FQ_DEPTH = 4;

  localparam int S_STEPS  = 32;
  localparam int AN_STEPS = 69;
  localparam int VQ_STEPS = 49;
  localparam int AQ_STEPS = 49;

  typedef struct packed {
    logic [TIME_W-1:0]       start_time;
    logic signed [POS_W-1:0] start_position;
    logic signed [POS_W-1:0] end_position;
    logic [DUR_W-1:0]        move_duration;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [DUR_W-1:0] dt;
  } fq_entry_t;

  typedef struct packed {
    logic      valid;
    fq_entry_t entry;
  } fq_out_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  position;
    logic signed [RATE_W-1:0] velocity;
    logic signed [RATE_W-1:0] acceleration;
    phase_t                   phase;
  } result_t;

endpackage

[rtl/mjt_front.sv]
// ----------------------------------------------------------------------------
// Minimum-jerk front end
// Accepts time samples, classifies the phase of the move and queues work.
// ----------------------------------------------------------------------------
module mjt_front (
  input  logic                      clk,
  input  logic                      rst,
  input  mjt_pkg::cfg_t             cfg,
  input  logic                      push,
  input  logic [mjt_pkg::TIME_W-1:0] time_now,
  output logic                      full,
  output mjt_pkg::fq_out_t          head,
  input  logic                      take
);
  import mjt_pkg::*;

  localparam int PW = $clog2(FQ_DEPTH);

  fq_entry_t       fq_mem [FQ_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     count;
  logic [TIME_W:0] diff;
  logic            done;
  fq_entry_t       entry;
  logic            wr_ok;
  logic            rd_ok;

  assign diff = {1'b0, time_now} - {1'b0, cfg.start_time};
  assign done = diff[TIME_W-1:0] >= TIME_W'(cfg.move_duration);

  always_comb begin
    entry.dt = '0;
    if (diff[TIME_W]) begin
      entry.phase = PH_BEFORE;
    end else if (done) begin
      entry.phase = PH_DONE;
    end else begin
      entry.phase = PH_MOVING;
      entry.dt    = diff[DUR_W-1:0];
    end
  end

  assign full  = count == (PW+1)'(FQ_DEPTH);
  assign wr_ok = push & ~full;
  assign rd_ok = take & head.valid;

  assign head.valid = count != '0;
  assign head.entry = fq_mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_ok) wptr <= wptr + 1'b1;
      if (rd_ok) rptr <= rptr + 1'b1;
      count <= count + (PW+1)'(wr_ok) - (PW+1)'(rd_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) fq_mem[wptr] <= entry;
  end

endmodule

[rtl/mjt_back.sv]
// ----------------------------------------------------------------------------
// Minimum-jerk back end
// Pipelined quintic evaluation with bit-per-stage dividers and result queue.
// ----------------------------------------------------------------------------
module mjt_back (
  input  logic             clk,
  input  logic             rst,
  input  mjt_pkg::cfg_t    cfg,
  input  mjt_pkg::fq_out_t head,
  output logic             take,
  output logic             empty,
  input  logic             pop,
  output mjt_pkg::result_t res
);
  import mjt_pkg::*;

  localparam int NA = S_STEPS;
  localparam int NB = AN_STEPS;
  localparam int NV = VQ_STEPS;
  localparam int NC = AQ_STEPS;

  function automatic logic [32:0] dstep(logic [31:0] rem, logic bin, logic [31:0] d);
    logic [32:0] r2;
    r2 = {rem, bin};
    if (r2 >= {1'b0, d}) return {1'b1, 32'(r2 - {1'b0, d})};
    else return {1'b0, r2[31:0]};
  endfunction

  function automatic logic [47:0] sat48(logic [48:0] mag, logic ovf, logic neg);
    logic [48:0] lim;
    logic [48:0] m;
    lim = neg ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;
    m   = (ovf || mag > lim) ? lim : mag;
    return neg ? 48'(-m) : 48'(m);
  endfunction

  logic [DUR_W-1:0] dur;
  logic signed [32:0] dsub;
  logic [31:0] dabs;
  logic        dneg;
  logic [30:0] thalf;
  logic        adv;
  logic        oq_full;

  assign dur  = cfg.move_duration;
  assign dsub = {cfg.end_position[31], cfg.end_position}
              - {cfg.start_position[31], cfg.start_position};

  always_ff @(posedge clk) begin
    dneg  <= dsub[32];
    dabs  <= dsub[32] ? 32'(-dsub) : dsub[31:0];
    thalf <= dur[31:1];
  end

  // Segment A: s = dt * 2^32 / T.
  logic [NA:0] a_vld;
  phase_t      a_ph  [NA+1];
  logic [31:0] a_rem [NA+1];
  logic [31:0] a_q   [NA+1];
  logic [32:0] a_nx  [NA];

  // Polynomial stages.
  logic [3:0]  m_vld;
  phase_t      m1_ph, m2_ph, m3_ph, m4_ph;
  logic        m1_hneg, m2_hneg, m3_hneg, m4_hneg;
  logic [31:0] m1_s;
  logic [30:0] m1_q;
  logic [32:0] m1_s2;
  logic [32:0] m1_habs;
  logic [32:0] m2_s3;
  logic [28:0] m2_q2;
  logic [29:0] m2_a;
  logic [35:0] m2_g;
  logic [36:0] m3_p;
  logic [64:0] m3_vn;
  logic [67:0] m3_an;
  logic [37:0] m4_w;
  logic [65:0] m4_vx;
  logic [68:0] m4_ax;

  // Segment B: acceleration first quotient and velocity quotient.
  logic [NB:0] b_vld;
  phase_t      b_ph   [NB+1];
  logic        b_hneg [NB+1];
  logic [31:0] b_pos  [NB+1];
  logic [31:0] b_rem  [NB+1];
  logic [68:0] b_x    [NB+1];
  logic [31:0] b_vrem [NB+1];
  logic [48:0] b_vx   [NB+1];
  logic        b_vovf [NB+1];
  logic [32:0] b_nx   [NB];
  logic [32:0] b_vnx  [NB];

  // Segment C: acceleration second quotient.
  logic [NC:0] c_vld;
  phase_t      c_ph   [NC+1];
  logic        c_hneg [NC+1];
  logic [31:0] c_pos  [NC+1];
  logic [31:0] c_rem  [NC+1];
  logic [48:0] c_x    [NC+1];
  logic        c_ovf  [NC+1];
  logic [48:0] c_vq   [NC+1];
  logic        c_vovf [NC+1];
  logic [32:0] c_nx   [NC];

  assign adv  = ~(c_vld[NC] & oq_full);
  assign take = adv & head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= '0;
      m_vld <= '0;
      b_vld <= '0;
      c_vld <= '0;
    end else if (adv) begin
      a_vld <= {a_vld[NA-1:0], take};
      m_vld <= {m_vld[2:0], a_vld[NA]};
      b_vld <= {b_vld[NB-1:0], m_vld[3]};
      c_vld <= {c_vld[NC-1:0], b_vld[NB]};
    end
  end

  always_comb begin
    for (int k = 0; k < NA; k++) a_nx[k] = dstep(a_rem[k], 1'b0, dur);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ph[0]  <= head.entry.phase;
      a_rem[0] <= head.entry.dt;
      a_q[0]   <= '0;
      for (int k = 0; k < NA; k++) begin
        a_ph[k+1]  <= a_ph[k];
        a_rem[k+1] <= a_nx[k][31:0];
        a_q[k+1]   <= {a_q[k][30:0], a_nx[k][32]};
      end
    end
  end

  logic [32:0] sr;
  logic [64:0] p_sr;
  logic [63:0] p_ss;
  logic [32:0] two_s;
  logic        hn;

  assign sr    = 33'h1_0000_0000 - {1'b0, a_q[NA]};
  assign p_sr  = a_q[NA] * sr;
  assign p_ss  = a_q[NA] * a_q[NA];
  assign two_s = {a_q[NA], 1'b0};
  assign hn    = two_s > 33'h1_0000_0000;

  logic [64:0] p_s3;
  logic [61:0] p_q2;
  logic [63:0] p_a;
  logic [37:0] gp;
  logic [37:0] gn;

  assign p_s3 = m1_s2 * m1_s;
  assign p_q2 = m1_q * m1_q;
  assign p_a  = m1_q * m1_habs;
  assign gp   = 38'h0A_0000_0000 + 38'(m1_s2) * 38'd6;
  assign gn   = 38'(m1_s) * 38'd15;

  logic [68:0] p_p;
  logic [68:0] p_w;

  assign p_p = m2_s3 * m2_g;
  assign p_w = dabs * m3_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_ph   <= a_ph[NA];
      m1_s    <= a_q[NA];
      m1_q    <= 31'(p_sr[64:32] + 33'(p_sr[31]));
      m1_s2   <= {1'b0, p_ss[63:32]} + 33'(p_ss[31]);
      m1_hneg <= hn;
      m1_habs <= hn ? two_s - 33'h1_0000_0000 : 33'h1_0000_0000 - two_s;

      m2_ph   <= m1_ph;
      m2_hneg <= m1_hneg;
      m2_s3   <= 33'(p_s3[64:32] + 33'(p_s3[31]));
      m2_q2   <= 29'(p_q2[61:32] + 30'(p_q2[31]));
      m2_a    <= 30'(p_a[63:32] + 32'(p_a[31]));
      m2_g    <= (gp > gn) ? 36'(gp - gn) : '0;

      m3_ph   <= m2_ph;
      m3_hneg <= m2_hneg;
      m3_p    <= 37'(p_p[68:32] + 37'(p_p[31]));
      m3_vn   <= dabs * (33'(m2_q2) * 33'd30);
      m3_an   <= dabs * (36'(m2_a) * 36'd60);

      m4_ph   <= m3_ph;
      m4_hneg <= m3_hneg;
      m4_w    <= 38'(p_w[68:32]) + 38'(p_w[31]);
      m4_vx   <= 66'(m3_vn) + 66'(thalf);
      m4_ax   <= 69'(m3_an) + 69'(thalf);
    end
  end

  logic signed [39:0] st_x;
  logic signed [39:0] pos_sum;
  logic [31:0]        pos_sat;
  logic [16:0]        v_hi;

  assign st_x    = 40'(cfg.start_position);
  assign pos_sum = dneg ? st_x - signed'({2'b00, m4_w}) : st_x + signed'({2'b00, m4_w});
  assign v_hi    = m4_vx[65:49];

  always_comb begin
    if (pos_sum > 40'sd2147483647) pos_sat = 32'h7FFF_FFFF;
    else if (pos_sum < -40'sd2147483648) pos_sat = 32'h8000_0000;
    else pos_sat = pos_sum[31:0];
  end

  always_comb begin
    for (int k = 0; k < NB; k++) begin
      b_nx[k]  = dstep(b_rem[k], b_x[k][68], dur);
      b_vnx[k] = dstep(b_vrem[k], b_vx[k][48], dur);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ph[0]   <= m4_ph;
      b_hneg[0] <= m4_hneg;
      b_pos[0]  <= pos_sat;
      b_rem[0]  <= '0;
      b_x[0]    <= m4_ax;
      b_vrem[0] <= 32'(v_hi);
      b_vx[0]   <= m4_vx[48:0];
      b_vovf[0] <= 32'(v_hi) >= dur;
      for (int k = 0; k < NB; k++) begin
        b_ph[k+1]   <= b_ph[k];
        b_hneg[k+1] <= b_hneg[k];
        b_pos[k+1]  <= b_pos[k];
        b_vovf[k+1] <= b_vovf[k];
        b_rem[k+1]  <= b_nx[k][31:0];
        b_x[k+1]    <= {b_x[k][67:0], b_nx[k][32]};
        if (k < NV) begin
          b_vrem[k+1] <= b_vnx[k][31:0];
          b_vx[k+1]   <= {b_vx[k][47:0], b_vnx[k][32]};
        end else begin
          b_vrem[k+1] <= b_vrem[k];
          b_vx[k+1]   <= b_vx[k];
        end
      end
    end
  end

  logic [69:0] x2;

  assign x2 = {1'b0, b_x[NB]} + 70'(thalf);

  always_comb begin
    for (int k = 0; k < NC; k++) c_nx[k] = dstep(c_rem[k], c_x[k][48], dur);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ph[0]   <= b_ph[NB];
      c_hneg[0] <= b_hneg[NB];
      c_pos[0]  <= b_pos[NB];
      c_rem[0]  <= 32'(x2[69:49]);
      c_ovf[0]  <= 32'(x2[69:49]) >= dur;
      c_x[0]    <= x2[48:0];
      c_vq[0]   <= b_vx[NB];
      c_vovf[0] <= b_vovf[NB];
      for (int k = 0; k < NC; k++) begin
        c_ph[k+1]   <= c_ph[k];
        c_hneg[k+1] <= c_hneg[k];
        c_pos[k+1]  <= c_pos[k];
        c_ovf[k+1]  <= c_ovf[k];
        c_vq[k+1]   <= c_vq[k];
        c_vovf[k+1] <= c_vovf[k];
        c_rem[k+1]  <= c_nx[k][31:0];
        c_x[k+1]    <= {c_x[k][47:0], c_nx[k][32]};
      end
    end
  end

  result_t fin;

  always_comb begin
    fin.phase        = c_ph[NC];
    fin.position     = c_pos[NC];
    fin.velocity     = sat48(c_vq[NC], c_vovf[NC], dneg);
    fin.acceleration = sat48(c_x[NC], c_ovf[NC], dneg ^ c_hneg[NC]);
    case (c_ph[NC])
      PH_BEFORE: begin
        fin.position     = cfg.start_position;
        fin.velocity     = '0;
        fin.acceleration = '0;
      end
      PH_DONE: begin
        fin.position     = cfg.end_position;
        fin.velocity     = '0;
        fin.acceleration = '0;
      end
      default: begin
      end
    endcase
  end

  result_t    oq_mem [2];
  logic       oq_w;
  logic       oq_r;
  logic [1:0] oq_cnt;
  logic       oq_push;
  logic       oq_pop;

  assign oq_full = oq_cnt == 2'd2;
  assign empty   = oq_cnt == 2'd0;
  assign oq_push = c_vld[NC] & ~oq_full;
  assign oq_pop  = pop & ~empty;
  assign res     = oq_mem[oq_r];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_w   <= 1'b0;
      oq_r   <= 1'b0;
      oq_cnt <= '0;
    end else begin
      if (oq_push) oq_w <= ~oq_w;
      if (oq_pop) oq_r <= ~oq_r;
      oq_cnt <= oq_cnt + 2'(oq_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_mem[oq_w] <= fin;
  end

endmodule

[rtl/min_jerk_trajectory_eval.sv]
// A new time sample can be pushed every clock cycle while the input queue is not
// full, and results come out in order, one per sample. The pipeline holds four
// restoring dividers (by the move duration), which resolve one quotient bit per
// pipeline stage. The pipeline stalls only while its result queue is full, and
// the input queue absorbs four samples during such a stall.
// ----------------------------------------------------------------------------
// Minimum-jerk trajectory evaluator
// Top level: configuration registers, front end and evaluation back end.
// ----------------------------------------------------------------------------
module min_jerk_trajectory_eval (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  mjt_pkg::reg_idx_t                 cfg_index,
  input  logic [mjt_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [mjt_pkg::TIME_W-1:0]        time_now,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [mjt_pkg::POS_W-1:0]  position,
  output logic signed [mjt_pkg::RATE_W-1:0] velocity,
  output logic signed [mjt_pkg::RATE_W-1:0] acceleration,
  output mjt_pkg::phase_t                   phase
);
  import mjt_pkg::*;

  cfg_t    cfg;
  fq_out_t head;
  logic    take;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_time     <= '0;
      cfg.start_position <= '0;
      cfg.end_position   <= '0;
      cfg.move_duration  <= DUR_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_TIME: cfg.start_time     <= cfg_data;
        REG_START_POS:  cfg.start_position <= cfg_data[POS_W-1:0];
        REG_END_POS:    cfg.end_position   <= cfg_data[POS_W-1:0];
        REG_DURATION:   cfg.move_duration  <= cfg_data[DUR_W-1:0];
      endcase
    end
  end

  mjt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .time_now (time_now),
    .full     (full),
    .head     (head),
    .take     (take)
  );

  mjt_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .take  (take),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  assign position     = res.position;
  assign velocity     = res.velocity;
  assign acceleration = res.acceleration;
  assign phase        = res.phase;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue is not empty after reset.");

  a_before_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && phase == PH_BEFORE) |->
      (position == cfg.start_position && velocity == '0 && acceleration == '0))
    else $error("A request before the move start does not hold the start position.");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && phase == PH_DONE) |->
      (position == cfg.end_position && velocity == '0 && acceleration == '0))
    else $error("A request after the move end does not hold the end position.");

  a_still_move: assert property (@(posedge clk) disable iff (rst)
    (!empty && phase == PH_MOVING && cfg.start_position == cfg.end_position) |->
      (velocity == '0 && acceleration == '0 && position == cfg.start_position))
    else $error("A move of zero length produced motion.");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Minimum-jerk trajectory evaluator testbench
// Drives time samples through the queue ports under several move settings and
// checks each result against a bit-accurate fixed-point trajectory predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import mjt_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  reg_idx_t                 cfg_index = REG_START_TIME;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     push = 1'b0;
  logic                     full;
  logic [TIME_W-1:0]        time_now = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic signed [POS_W-1:0]  position;
  logic signed [RATE_W-1:0] velocity;
  logic signed [RATE_W-1:0] acceleration;
  phase_t                   phase;

  min_jerk_trajectory_eval dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [TIME_W-1:0]        mv_start = '0;
  logic signed [POS_W-1:0]  mv_from = '0;
  logic signed [POS_W-1:0]  mv_to = '0;
  logic [DUR_W-1:0]         mv_dur = 32'd1;

  logic [TIME_W-1:0] sample_times[$];
  result_t           expected_samples[$];
  int                mismatches = 0;
  int                idle_mode = 1;
  longint            cycles = 0;

  function automatic logic [127:0] rnd32(logic [127:0] x);
    return (x + 128'h8000_0000) >> 32;
  endfunction

  function automatic logic [127:0] div_round(logic [127:0] x, logic [127:0] d);
    return (x + (d >> 1)) / d;
  endfunction

  function automatic logic [RATE_W-1:0] clamp_rate(logic [127:0] mag, logic neg);
    logic [127:0] lim;
    logic [127:0] m;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    m = (mag > lim) ? lim : mag;
    return neg ? -m[RATE_W-1:0] : m[RATE_W-1:0];
  endfunction

  function automatic result_t traj_sample(logic [TIME_W-1:0] now);
    result_t res;
    logic [TIME_W-1:0] dt;
    logic [127:0] s, r, q, s2, s3, g, p, w, q2, a, habs, dabs;
    longint d, gs, h, pl;
    logic dneg;
    res = '0;
    if (now < mv_start) begin
      res.position = mv_from;
      res.phase = PH_BEFORE;
      return res;
    end
    dt = now - mv_start;
    if (dt >= {8'd0, mv_dur}) begin
      res.position = mv_to;
      res.phase = PH_DONE;
      return res;
    end
    d = longint'(mv_to) - longint'(mv_from);
    dneg = d < 0;
    dabs = dneg ? 128'(-d) : 128'(d);
    s = {64'd0, dt[31:0], 32'd0} / {96'd0, mv_dur};
    r = 128'h1_0000_0000 - s;
    q = rnd32(s * r);
    s2 = rnd32(s * s);
    s3 = rnd32(s2 * s);
    gs = 64'sh0000_000A_0000_0000 - 15 * longint'(s[63:0]) + 6 * longint'(s2[63:0]);
    g = (gs < 0) ? 128'd0 : 128'(gs);
    p = rnd32(s3 * g);
    w = rnd32(dabs * p);
    pl = longint'(mv_from) + (dneg ? -longint'(w[63:0]) : longint'(w[63:0]));
    if (pl > 64'sd2147483647) pl = 64'sd2147483647;
    if (pl < -64'sd2147483648) pl = -64'sd2147483648;
    res.position = pl[31:0];
    q2 = rnd32(q * q);
    res.velocity = clamp_rate(div_round(dabs * 30 * q2, {96'd0, mv_dur}), dneg);
    h = 64'sh1_0000_0000 - 2 * longint'(s[63:0]);
    habs = (h < 0) ? 128'(-h) : 128'(h);
    a = rnd32(q * habs);
    res.acceleration = clamp_rate(div_round(div_round(dabs * 60 * a, {96'd0, mv_dur}),
                                            {96'd0, mv_dur}), dneg ^ (h < 0));
    res.phase = PH_MOVING;
    return res;
  endfunction

  function automatic int idle_len();
    int k;
    if (idle_mode == 0) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  int push_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_samples.push_back(traj_sample(time_now));
        push_gap = idle_len();
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (push_gap > 0) begin
        push_gap = push_gap - 1;
        push <= 1'b0;
      end else if (sample_times.size() > 0) begin
        time_now <= sample_times.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  int pop_gap = 0;
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: pos %0d", position);
        end else begin
          exp_r = expected_samples.pop_front();
          if (position !== exp_r.position || velocity !== exp_r.velocity ||
              acceleration !== exp_r.acceleration || phase !== exp_r.phase) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp pos %0d vel %0d acc %0d ph %0d, got %0d %0d %0d %0d",
                       exp_r.position, exp_r.velocity, exp_r.acceleration, exp_r.phase,
                       position, velocity, acceleration, phase);
          end
        end
        pop_gap = idle_len();
      end
      if (pop_gap > 0) begin
        pop_gap = pop_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_START_TIME: mv_start = val;
      REG_START_POS:  mv_from = val[31:0];
      REG_END_POS:    mv_to = val[31:0];
      REG_DURATION:   mv_dur = val[31:0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_move(logic [39:0] st, logic [31:0] from, logic [31:0] to,
                          logic [31:0] dur);
    write_reg(REG_START_TIME, st);
    write_reg(REG_START_POS, {8'd0, from});
    write_reg(REG_END_POS, {8'd0, to});
    write_reg(REG_DURATION, {8'd0, dur});
  endtask

  task automatic wait_idle();
    while (sample_times.size() != 0 || push || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [39:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  initial begin
    logic [39:0] st;
    logic [31:0] dur;
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    sample_times = '{40'd0, 40'd1, 40'hFF_FFFF_FFFF};
    wait_idle();

    set_move(40'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd100);
    sample_times = '{40'd0, 40'd999, 40'd1000, 40'd1001, 40'd1025, 40'd1050,
                     40'd1075, 40'd1099, 40'd1100, 40'hFF_FFFF_FFFF};
    wait_idle();

    set_move(40'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    sample_times = '{40'd1, 40'h7FFF_FFFF, 40'h8000_0000, 40'hFFFF_FFFE, 40'hFFFF_FFFF};
    wait_idle();

    set_move(40'hFF_FFFF_FFFF, 32'd65536, 32'd65536, 32'd0);
    sample_times = '{40'hFF_FFFF_FFFE, 40'hFF_FFFF_FFFF};
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      idle_mode = (ph % 4 == 1) ? 0 : 1;
      dur = (ph % 3 == 2) ? $urandom() | 32'd1 : $urandom_range(1, 1000);
      st = (ph % 2) ? rand40() : 40'($urandom_range(0, 100000));
      k = $urandom_range(0, 3);
      set_move(st, (k == 0) ? 32'h8000_0000 : $urandom(),
               (k == 1) ? 32'h7FFF_FFFF : $urandom(), dur);
      for (int i = 0; i < 190; i++) begin
        k = $urandom_range(0, 9);
        if (k < 7) sample_times.push_back(st + $urandom_range(0, dur - 1));
        else if (k < 9) sample_times.push_back(st + $urandom_range(0, 2 * dur) - dur / 2);
        else sample_times.push_back(rand40());
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mjt_pkg.sv
rtl/mjt_front.sv
rtl/mjt_back.sv
rtl/min_jerk_trajectory_eval.sv
test/tb_top.sv
